// ===== src/cfa_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the frame allocator.
package cfa_pkg;

   // Frame map depth and derived widths
   localparam int MAX_FRAMES  = 1024;
   localparam int INDEX_W     = $clog2(MAX_FRAMES);
   localparam int SIZE_W      = $clog2(MAX_FRAMES + 1);
   localparam int FRAME_W     = 20;
   localparam int COUNT_W     = 11;
   localparam int POOL_W      = 11;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 3;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 20;
   localparam int CMP_W       = (SIZE_W > COUNT_W) ? SIZE_W : COUNT_W;
   localparam int LIVE_CMP_W  = (SIZE_W > POOL_W) ? SIZE_W : POOL_W;

   // Reset values of the configuration registers
   localparam logic [FRAME_W-1:0] BASE_FRAME_RESET = '0;
   localparam logic [POOL_W-1:0]  POOL_SIZE_RESET  = POOL_W'(1024);

   typedef enum logic [OP_W-1:0] {
      OP_ALLOCATE = 2'd0,
      OP_RELEASE  = 2'd1,
      OP_RESERVE  = 2'd2,
      OP_CLEAR    = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK          = 3'd0,
      STS_NO_SPACE    = 3'd1,
      STS_OUT_OF_POOL = 3'd2,
      STS_NOT_HEAD    = 3'd3,
      STS_BAD_COUNT   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FS_FREE = 2'd0,
      FS_USED = 2'd1,
      FS_HEAD = 2'd2
   } fs_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_FRAME = 2'd0,
      CSR_POOL_SIZE  = 2'd1,
      CSR_MAP_INSIDE = 2'd2
   } csr_index_type;

   // Datapath commands, one per cycle
   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,
      DP_SCAN_START,
      DP_REL_START,
      DP_RSV_START,
      DP_SCAN_ALLOC,
      DP_SCAN_REL,
      DP_MARK,
      DP_WIPE,
      DP_CLR_HEAD,
      DP_SET_STATUS,
      DP_RESPOND
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      status_type code;
   } dp_cmd_type;

   // Datapath status back to the controller
   typedef struct packed {
      op_type op;
      logic   count_zero;
      logic   in_pool;
      logic   rsv_fits;
      logic   found;
      logic   exhausted;
      logic   not_head;
      logic   rel_stop;
      logic   mark_last;
      logic   wipe_last;
      logic   out_free;
   } dp_flags_type;

   typedef enum logic [3:0] {
      S_INIT_WIPE,
      S_IDLE,
      S_DECODE,
      S_ALLOC_SCAN,
      S_MARK,
      S_REL_SCAN,
      S_CLR_WIPE,
      S_CLR_HEAD,
      S_FINISH
   } ctl_state_type;

endpackage

// ===== src/cfa_datapath.sv =====
// Frame map memory, scan pointers, configuration registers and result register.
module cfa_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  cfa_pkg::dp_cmd_type                 cmd,
   output cfa_pkg::dp_flags_type               flags,
   input  logic [cfa_pkg::OP_W-1:0]            req_operation,
   input  logic [cfa_pkg::FRAME_W-1:0]         req_frame_number,
   input  logic [cfa_pkg::COUNT_W-1:0]         req_count,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cfa_pkg::FRAME_W-1:0]         rsp_result_frame,
   output logic [cfa_pkg::STATUS_W-1:0]        rsp_status,
   input  logic                                csr_we,
   input  logic [cfa_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cfa_pkg::CSR_DATA_W-1:0]      csr_data
);

   // Configuration registers
   logic [cfa_pkg::FRAME_W-1:0]  base_ff, base_in;
   logic [cfa_pkg::POOL_W-1:0]   pool_ff, pool_in;
   logic                         map_ff, map_in;

   // Latched item
   cfa_pkg::op_type              op_ff, op_in;
   logic [cfa_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [cfa_pkg::FRAME_W-1:0]  off_ff, off_in;
   logic                         below_ff, below_in;

   // Scan and mark pointers
   logic [cfa_pkg::SIZE_W-1:0]   idx_ff, idx_in;
   logic [cfa_pkg::INDEX_W-1:0]  pidx_ff, pidx_in;
   logic                         pvalid_ff, pvalid_in;
   logic [cfa_pkg::SIZE_W-1:0]   run_ff, run_in;
   logic [cfa_pkg::INDEX_W-1:0]  start_ff, start_in;
   logic [cfa_pkg::COUNT_W-1:0]  cnt_ff, cnt_in;

   // Pending and delivered result
   logic [cfa_pkg::FRAME_W-1:0]  res_ff, res_in;
   cfa_pkg::status_type          sts_ff, sts_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [cfa_pkg::FRAME_W-1:0]  rsp_res_ff, rsp_res_in;
   cfa_pkg::status_type          rsp_sts_ff, rsp_sts_in;

   // Frame map memory
   cfa_pkg::fs_type              frame_map_mem [cfa_pkg::MAX_FRAMES];
   cfa_pkg::fs_type              rd_state_ff;
   logic                         mem_we;
   logic [cfa_pkg::INDEX_W-1:0]  mem_waddr;
   cfa_pkg::fs_type              mem_wdata;

   logic [cfa_pkg::SIZE_W-1:0]   live_size;
   logic [cfa_pkg::SIZE_W-1:0]   room;
   logic [cfa_pkg::SIZE_W-1:0]   start_wide;
   logic [cfa_pkg::INDEX_W-1:0]  alloc_start;
   logic                         pool_big;
   logic                         issue;
   logic                         found;
   logic                         rel_write;

   // Pool size clamped to the map depth
   assign pool_big  = cfa_pkg::LIVE_CMP_W'(pool_ff) >
                      cfa_pkg::LIVE_CMP_W'(cfa_pkg::MAX_FRAMES);
   assign live_size = pool_big ? cfa_pkg::SIZE_W'(cfa_pkg::MAX_FRAMES)
                               : cfa_pkg::SIZE_W'(pool_ff);

   // Room from the offset to the end of the pool; meaningful only inside the pool
   assign room = live_size - cfa_pkg::SIZE_W'(off_ff);

   // A scan read is issued while the pointer is still inside the pool
   assign issue = idx_ff < live_size;

   // First fit: run of free frames reaches the requested count
   assign found = pvalid_ff && (rd_state_ff == cfa_pkg::FS_FREE) &&
                  (cfa_pkg::CMP_W'(run_ff) + cfa_pkg::CMP_W'(1) ==
                   cfa_pkg::CMP_W'(count_ff));
   assign start_wide  = cfa_pkg::SIZE_W'(pidx_ff) + cfa_pkg::SIZE_W'(1) -
                        cfa_pkg::SIZE_W'(count_ff);
   assign alloc_start = start_wide[cfa_pkg::INDEX_W-1:0];

   // Release frees the head, then each used frame that follows
   assign rel_write = pvalid_ff &&
                      (((pidx_ff == start_ff) && (rd_state_ff == cfa_pkg::FS_HEAD)) ||
                       ((pidx_ff != start_ff) && (rd_state_ff == cfa_pkg::FS_USED)));

   // Status to the controller
   always_comb begin
      flags.op         = op_ff;
      flags.count_zero = (count_ff == '0);
      flags.in_pool    = !below_ff && (cfa_pkg::FRAME_W'(live_size) > off_ff);
      flags.rsv_fits   = cfa_pkg::CMP_W'(count_ff) <= cfa_pkg::CMP_W'(room);
      flags.found      = found;
      flags.exhausted  = !pvalid_ff && !issue;
      flags.not_head   = pvalid_ff && (pidx_ff == start_ff) &&
                         (rd_state_ff != cfa_pkg::FS_HEAD);
      flags.rel_stop   = pvalid_ff && (pidx_ff != start_ff) &&
                         (rd_state_ff != cfa_pkg::FS_USED);
      flags.mark_last  = (cnt_ff == cfa_pkg::COUNT_W'(1));
      flags.wipe_last  = (idx_ff[cfa_pkg::INDEX_W-1:0] ==
                          cfa_pkg::INDEX_W'(cfa_pkg::MAX_FRAMES - 1));
      flags.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Next-state logic for all datapath registers
   always_comb begin
      base_in      = base_ff;
      pool_in      = pool_ff;
      map_in       = map_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      off_in       = off_ff;
      below_in     = below_ff;
      idx_in       = idx_ff;
      pidx_in      = pidx_ff;
      pvalid_in    = pvalid_ff;
      run_in       = run_ff;
      start_in     = start_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      sts_in       = sts_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_sts_in   = rsp_sts_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff[cfa_pkg::INDEX_W-1:0];
      mem_wdata    = cfa_pkg::FS_FREE;

      // delivered word leaves the output register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // configuration writes
      if (csr_we) begin
         case (cfa_pkg::csr_index_type'(csr_index))
            cfa_pkg::CSR_BASE_FRAME: base_in = csr_data[cfa_pkg::FRAME_W-1:0];
            cfa_pkg::CSR_POOL_SIZE:  pool_in = csr_data[cfa_pkg::POOL_W-1:0];
            cfa_pkg::CSR_MAP_INSIDE: map_in  = csr_data[0];
            default: ;
         endcase
      end

      case (cmd.op)
         cfa_pkg::DP_LOAD: begin
            op_in    = cfa_pkg::op_type'(req_operation);
            count_in = req_count;
            off_in   = req_frame_number - base_ff;
            below_in = req_frame_number < base_ff;
            res_in   = '0;
            sts_in   = cfa_pkg::STS_OK;
         end
         cfa_pkg::DP_SCAN_START: begin
            idx_in    = '0;
            run_in    = '0;
            pvalid_in = 1'b0;
         end
         cfa_pkg::DP_REL_START: begin
            idx_in    = cfa_pkg::SIZE_W'(off_ff);
            start_in  = cfa_pkg::INDEX_W'(off_ff);
            pvalid_in = 1'b0;
         end
         cfa_pkg::DP_RSV_START: begin
            idx_in   = cfa_pkg::SIZE_W'(off_ff);
            start_in = cfa_pkg::INDEX_W'(off_ff);
            cnt_in   = count_ff;
         end
         cfa_pkg::DP_SCAN_ALLOC: begin
            pvalid_in = issue;
            if (issue) begin
               pidx_in = idx_ff[cfa_pkg::INDEX_W-1:0];
               idx_in  = idx_ff + cfa_pkg::SIZE_W'(1);
            end
            if (pvalid_ff) begin
               run_in = (rd_state_ff == cfa_pkg::FS_FREE) ?
                        run_ff + cfa_pkg::SIZE_W'(1) : '0;
            end
            // run found: set up the mark pass
            if (found) begin
               start_in = alloc_start;
               idx_in   = cfa_pkg::SIZE_W'(alloc_start);
               cnt_in   = count_ff;
               res_in   = base_ff + cfa_pkg::FRAME_W'(alloc_start);
            end
         end
         cfa_pkg::DP_SCAN_REL: begin
            pvalid_in = issue;
            if (issue) begin
               pidx_in = idx_ff[cfa_pkg::INDEX_W-1:0];
               idx_in  = idx_ff + cfa_pkg::SIZE_W'(1);
            end
            if (rel_write) begin
               mem_we    = 1'b1;
               mem_waddr = pidx_ff;
               mem_wdata = cfa_pkg::FS_FREE;
            end
         end
         cfa_pkg::DP_MARK: begin
            mem_we    = 1'b1;
            mem_wdata = (idx_ff[cfa_pkg::INDEX_W-1:0] == start_ff) ?
                        cfa_pkg::FS_HEAD : cfa_pkg::FS_USED;
            idx_in    = idx_ff + cfa_pkg::SIZE_W'(1);
            cnt_in    = cnt_ff - cfa_pkg::COUNT_W'(1);
         end
         cfa_pkg::DP_WIPE: begin
            mem_we    = 1'b1;
            mem_wdata = cfa_pkg::FS_FREE;
            idx_in    = idx_ff + cfa_pkg::SIZE_W'(1);
         end
         cfa_pkg::DP_CLR_HEAD: begin
            if (map_ff && (live_size != '0)) begin
               mem_we    = 1'b1;
               mem_waddr = '0;
               mem_wdata = cfa_pkg::FS_HEAD;
            end
         end
         cfa_pkg::DP_SET_STATUS: begin
            sts_in = cmd.code;
         end
         cfa_pkg::DP_RESPOND: begin
            rsp_valid_in = 1'b1;
            rsp_res_in   = res_ff;
            rsp_sts_in   = sts_ff;
         end
         default: ;
      endcase
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= cfa_pkg::BASE_FRAME_RESET;
         pool_ff      <= cfa_pkg::POOL_SIZE_RESET;
         map_ff       <= 1'b0;
         idx_ff       <= '0;
         pvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         pool_ff      <= pool_in;
         map_ff       <= map_in;
         idx_ff       <= idx_in;
         pvalid_ff    <= pvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      count_ff   <= count_in;
      off_ff     <= off_in;
      below_ff   <= below_in;
      pidx_ff    <= pidx_in;
      run_ff     <= run_in;
      start_ff   <= start_in;
      cnt_ff     <= cnt_in;
      res_ff     <= res_in;
      sts_ff     <= sts_in;
      rsp_res_ff <= rsp_res_in;
      rsp_sts_ff <= rsp_sts_in;
   end

   // Frame map: one write port, one registered read port at the scan pointer
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_map_mem[mem_waddr] <= mem_wdata;
      end
      rd_state_ff <= frame_map_mem[idx_ff[cfa_pkg::INDEX_W-1:0]];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_frame = rsp_res_ff;
   assign rsp_status       = rsp_sts_ff;

endmodule

// ===== src/cfa_controller.sv =====
// Sequencer for the frame allocator: drives datapath commands from its status flags.
module cfa_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output cfa_pkg::dp_cmd_type    cmd,
   input  cfa_pkg::dp_flags_type  flags
);

   cfa_pkg::ctl_state_type state_ff, state_in;

   // State register; reset starts the map wipe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfa_pkg::S_INIT_WIPE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd.op   = cfa_pkg::DP_NONE;
      cmd.code = cfa_pkg::STS_OK;

      case (state_ff)
         cfa_pkg::S_INIT_WIPE: begin
            cmd.op = cfa_pkg::DP_WIPE;
            if (flags.wipe_last) begin
               state_in = cfa_pkg::S_IDLE;
            end
         end
         cfa_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.op   = cfa_pkg::DP_LOAD;
               state_in = cfa_pkg::S_DECODE;
            end
         end
         cfa_pkg::S_DECODE: begin
            case (flags.op)
               cfa_pkg::OP_ALLOCATE: begin
                  if (flags.count_zero) begin
                     cmd.op   = cfa_pkg::DP_SET_STATUS;
                     cmd.code = cfa_pkg::STS_BAD_COUNT;
                     state_in = cfa_pkg::S_FINISH;
                  end else begin
                     cmd.op   = cfa_pkg::DP_SCAN_START;
                     state_in = cfa_pkg::S_ALLOC_SCAN;
                  end
               end
               cfa_pkg::OP_RELEASE: begin
                  if (!flags.in_pool) begin
                     cmd.op   = cfa_pkg::DP_SET_STATUS;
                     cmd.code = cfa_pkg::STS_OUT_OF_POOL;
                     state_in = cfa_pkg::S_FINISH;
                  end else begin
                     cmd.op   = cfa_pkg::DP_REL_START;
                     state_in = cfa_pkg::S_REL_SCAN;
                  end
               end
               cfa_pkg::OP_RESERVE: begin
                  if (flags.count_zero) begin
                     cmd.op   = cfa_pkg::DP_SET_STATUS;
                     cmd.code = cfa_pkg::STS_BAD_COUNT;
                     state_in = cfa_pkg::S_FINISH;
                  end else if (!flags.in_pool || !flags.rsv_fits) begin
                     cmd.op   = cfa_pkg::DP_SET_STATUS;
                     cmd.code = cfa_pkg::STS_OUT_OF_POOL;
                     state_in = cfa_pkg::S_FINISH;
                  end else begin
                     cmd.op   = cfa_pkg::DP_RSV_START;
                     state_in = cfa_pkg::S_MARK;
                  end
               end
               default: begin
                  cmd.op   = cfa_pkg::DP_SCAN_START;
                  state_in = cfa_pkg::S_CLR_WIPE;
               end
            endcase
         end
         cfa_pkg::S_ALLOC_SCAN: begin
            if (flags.exhausted) begin
               cmd.op   = cfa_pkg::DP_SET_STATUS;
               cmd.code = cfa_pkg::STS_NO_SPACE;
               state_in = cfa_pkg::S_FINISH;
            end else begin
               cmd.op = cfa_pkg::DP_SCAN_ALLOC;
               if (flags.found) begin
                  state_in = cfa_pkg::S_MARK;
               end
            end
         end
         cfa_pkg::S_MARK: begin
            cmd.op = cfa_pkg::DP_MARK;
            if (flags.mark_last) begin
               state_in = cfa_pkg::S_FINISH;
            end
         end
         cfa_pkg::S_REL_SCAN: begin
            if (flags.exhausted) begin
               state_in = cfa_pkg::S_FINISH;
            end else if (flags.not_head) begin
               cmd.op   = cfa_pkg::DP_SET_STATUS;
               cmd.code = cfa_pkg::STS_NOT_HEAD;
               state_in = cfa_pkg::S_FINISH;
            end else begin
               cmd.op = cfa_pkg::DP_SCAN_REL;
               if (flags.rel_stop) begin
                  state_in = cfa_pkg::S_FINISH;
               end
            end
         end
         cfa_pkg::S_CLR_WIPE: begin
            cmd.op = cfa_pkg::DP_WIPE;
            if (flags.wipe_last) begin
               state_in = cfa_pkg::S_CLR_HEAD;
            end
         end
         cfa_pkg::S_CLR_HEAD: begin
            cmd.op   = cfa_pkg::DP_CLR_HEAD;
            state_in = cfa_pkg::S_FINISH;
         end
         cfa_pkg::S_FINISH: begin
            if (flags.out_free) begin
               cmd.op   = cfa_pkg::DP_RESPOND;
               state_in = cfa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cfa_pkg::S_IDLE;
         end
      endcase
   end

   // New words are taken only between operations
   assign req_stall = (state_ff != cfa_pkg::S_IDLE);

endmodule

// ===== src/contiguous_frame_allocator_top.sv =====
// First-fit contiguous frame allocator, top level.
// Keeps a 2-bit state (free, used, head) per frame of one pool in a frame map memory
// of MAX_FRAMES (1024) entries with one write port and one registered read port, and
// serves one operation at a time.
// After reset the map is wiped one entry per cycle, with req_stall high until the
// wipe ends; configuration writes are taken at any time. Each operation then
// decodes and works through the map one entry per cycle: allocate scans from
// frame 0 until the first fitting run ends and then marks count entries; release
// walks the run from its head; reserve marks count entries; clear wipes all 1024
// entries. The result word is held in an output register, so a stalled result
// only holds up the next operation's final cycle, not its work.
module contiguous_frame_allocator_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [cfa_pkg::OP_W-1:0]         req_operation,
   input  logic [cfa_pkg::FRAME_W-1:0]      req_frame_number,
   input  logic [cfa_pkg::COUNT_W-1:0]      req_count,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [cfa_pkg::FRAME_W-1:0]      rsp_result_frame,
   output logic [cfa_pkg::STATUS_W-1:0]     rsp_status,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [cfa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cfa_pkg::CSR_DATA_W-1:0]   csr_data
);

   cfa_pkg::dp_cmd_type    cmd;
   cfa_pkg::dp_flags_type  flags;

   // Registers are always writable
   assign csr_ready = 1'b1;

   cfa_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .flags     (flags)
   );

   cfa_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .flags            (flags),
      .req_operation    (req_operation),
      .req_frame_number (req_frame_number),
      .req_count        (req_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_frame (rsp_result_frame),
      .rsp_status       (rsp_status),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

endmodule

// ===== src/cfa_checker.sv =====
// Port-level checks for the frame allocator and their binding to the top level.
module cfa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic [cfa_pkg::OP_W-1:0]         req_operation,
   input logic [cfa_pkg::FRAME_W-1:0]      req_frame_number,
   input logic [cfa_pkg::COUNT_W-1:0]      req_count,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [cfa_pkg::FRAME_W-1:0]      rsp_result_frame,
   input logic [cfa_pkg::STATUS_W-1:0]     rsp_status,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [cfa_pkg::CSR_INDEX_W-1:0]  csr_index,
   input logic [cfa_pkg::CSR_DATA_W-1:0]   csr_data
);

   // A held result word stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // A held result word keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_result_frame) && $stable(rsp_status))
      else $error("result payload changed while stalled");

   // Only one operation is in flight: an accepted word blocks the next
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word accepted before the operation finished");

   // Status codes stay inside the defined set
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= cfa_pkg::STATUS_W'(cfa_pkg::STS_BAD_COUNT))
      else $error("undefined status code");

   // A nonzero frame is reported only by a successful allocate
   a_frame_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_frame != '0) |->
         rsp_status == cfa_pkg::STATUS_W'(cfa_pkg::STS_OK))
      else $error("frame number returned with an error status");

endmodule

bind contiguous_frame_allocator_top cfa_checker u_cfa_checker (.*);

// ===== tb/tb_contiguous_frame_allocator_top.sv =====
// Self-checking testbench for the first-fit contiguous frame allocator top level.
`timescale 1ns / 1ps

module tb_contiguous_frame_allocator_top;

   localparam int unsigned LONG_HOLD   = 2000;   // result held off this many cycles
   localparam int unsigned IDLE_LIMIT  = 20000;  // cycles without any handshake
   localparam int unsigned TAIL_CYCLES = 2200;   // longest single operation plus margin

   typedef struct {
      cfa_pkg::op_type                op;
      logic [cfa_pkg::FRAME_W-1:0]    frame;
      logic [cfa_pkg::COUNT_W-1:0]    count;
   } frame_op_type;

   typedef struct {
      logic [cfa_pkg::FRAME_W-1:0]    result_frame;
      cfa_pkg::status_type            status;
   } answer_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   logic [cfa_pkg::OP_W-1:0]            req_operation = '0;
   logic [cfa_pkg::FRAME_W-1:0]         req_frame_number = '0;
   logic [cfa_pkg::COUNT_W-1:0]         req_count = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   logic [cfa_pkg::FRAME_W-1:0]         rsp_result_frame;
   logic [cfa_pkg::STATUS_W-1:0]        rsp_status;
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [cfa_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [cfa_pkg::CSR_DATA_W-1:0]      csr_data = '0;

   contiguous_frame_allocator_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_frame_number (req_frame_number),
      .req_count        (req_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_frame (rsp_result_frame),
      .rsp_status       (rsp_status),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // Shadow of the frame map and the pool registers
   cfa_pkg::fs_type              frame_map [cfa_pkg::MAX_FRAMES];
   logic [cfa_pkg::FRAME_W-1:0]  cfg_base = cfa_pkg::BASE_FRAME_RESET;
   logic [cfa_pkg::POOL_W-1:0]   cfg_pool = cfa_pkg::POOL_SIZE_RESET;
   logic                         cfg_map_inside = 1'b0;

   frame_op_type  op_queue [$];
   answer_type    expected_answers [$];
   int unsigned   fail_count = 0;

   // Handshake flags sampled at the rising edge, used at the next falling edge
   bit           req_taken = 1'b0;
   bit           rsp_taken = 1'b0;
   int unsigned  req_gap = 0;
   int unsigned  rsp_wait = 0;
   bit           no_idle = 1'b0;
   int unsigned  hold_asked = 0;
   int unsigned  hold_served = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Frames actually in view; oversized pools clamp to the map depth
   function automatic int unsigned live_frames();
      return (cfg_pool > cfa_pkg::MAX_FRAMES) ? cfa_pkg::MAX_FRAMES : int'(cfg_pool);
   endfunction

   // Applies one operation to the shadow map and returns the answer word
   function automatic answer_type apply_frame_op(cfa_pkg::op_type op,
                                                 logic [cfa_pkg::FRAME_W-1:0] frame,
                                                 logic [cfa_pkg::COUNT_W-1:0] count);
      answer_type   ans;
      int unsigned  frames, run, start, off, i;
      bit           in_pool;
      ans.result_frame = '0;
      ans.status       = cfa_pkg::STS_OK;
      frames  = live_frames();
      in_pool = (frame >= cfg_base) && (int'(frame) - int'(cfg_base) < frames);
      off     = int'(frame) - int'(cfg_base);
      case (op)
         cfa_pkg::OP_ALLOCATE: begin
            if (count == 0) begin
               ans.status = cfa_pkg::STS_BAD_COUNT;
            end else begin
               // first run of count free frames, lowest start wins
               ans.status = cfa_pkg::STS_NO_SPACE;
               run = 0;
               for (i = 0; i < frames; i++) begin
                  run = (frame_map[i] == cfa_pkg::FS_FREE) ? run + 1 : 0;
                  if (run == count) begin
                     start = i + 1 - count;
                     frame_map[start] = cfa_pkg::FS_HEAD;
                     for (int unsigned j = start + 1; j <= i; j++)
                        frame_map[j] = cfa_pkg::FS_USED;
                     ans.result_frame = cfa_pkg::FRAME_W'(int'(cfg_base) + start);
                     ans.status       = cfa_pkg::STS_OK;
                     break;
                  end
               end
            end
         end
         cfa_pkg::OP_RELEASE: begin
            if (!in_pool) begin
               ans.status = cfa_pkg::STS_OUT_OF_POOL;
            end else if (frame_map[off] != cfa_pkg::FS_HEAD) begin
               ans.status = cfa_pkg::STS_NOT_HEAD;
            end else begin
               frame_map[off] = cfa_pkg::FS_FREE;
               for (i = off + 1; i < frames && frame_map[i] == cfa_pkg::FS_USED; i++)
                  frame_map[i] = cfa_pkg::FS_FREE;
            end
         end
         cfa_pkg::OP_RESERVE: begin
            if (count == 0) begin
               ans.status = cfa_pkg::STS_BAD_COUNT;
            end else if (!in_pool || count > frames - off) begin
               ans.status = cfa_pkg::STS_OUT_OF_POOL;
            end else begin
               frame_map[off] = cfa_pkg::FS_HEAD;
               for (i = 1; i < count; i++) frame_map[off + i] = cfa_pkg::FS_USED;
            end
         end
         default: begin
            foreach (frame_map[k]) frame_map[k] = cfa_pkg::FS_FREE;
            if (cfg_map_inside && frames > 0) frame_map[0] = cfa_pkg::FS_HEAD;
         end
      endcase
      return ans;
   endfunction

   // Some head frame of the current pool, or any in-pool frame if none; any frame if the pool is empty
   function automatic logic [cfa_pkg::FRAME_W-1:0] pick_head();
      int unsigned frames, start, off;
      frames = live_frames();
      if (frames == 0) return cfa_pkg::FRAME_W'($urandom);
      start = $urandom_range(0, frames - 1);
      for (int unsigned k = 0; k < frames; k++) begin
         off = (start + k) % frames;
         if (frame_map[off] == cfa_pkg::FS_HEAD)
            return cfa_pkg::FRAME_W'(int'(cfg_base) + off);
      end
      return cfa_pkg::FRAME_W'(int'(cfg_base) + start);
   endfunction

   function automatic logic [cfa_pkg::FRAME_W-1:0] pool_frame();
      int unsigned frames;
      frames = live_frames();
      if (frames == 0) return cfa_pkg::FRAME_W'($urandom);
      return cfa_pkg::FRAME_W'(int'(cfg_base) + $urandom_range(0, frames - 1));
   endfunction

   function automatic logic [cfa_pkg::COUNT_W-1:0] draw_count();
      int unsigned r, frames;
      r      = $urandom_range(0, 99);
      frames = (live_frames() == 0) ? 1 : live_frames();
      if (r < 70) return cfa_pkg::COUNT_W'($urandom_range(1, 8));
      if (r < 88) return cfa_pkg::COUNT_W'($urandom_range(1, frames));
      if (r < 93) return '0;
      return cfa_pkg::COUNT_W'($urandom);
   endfunction

   // Op driver: one word per handshake, random gap after each accepted word
   always @(negedge clock) begin : drive_ops
      frame_op_type  op_word;
      logic          valid_next;
      valid_next = req_valid;
      if (reset) begin
         valid_next = 1'b0;
      end else begin
         if (req_valid && req_taken) begin
            valid_next = 1'b0;
            req_gap    = no_idle ? 0 : $urandom_range(0, 7);
         end
         if (!valid_next) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (op_queue.size() != 0) begin
               op_word = op_queue.pop_front();
               req_operation    <= op_word.op;
               req_frame_number <= op_word.frame;
               req_count        <= op_word.count;
               valid_next = 1'b1;
            end
         end
      end
      req_valid <= valid_next;
   end

   // Result stall: random wait per word, plus an occasional long hold-off
   always @(negedge clock) begin : drive_rsp_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_taken) rsp_wait = no_idle ? 0 : $urandom_range(0, 7);
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            rsp_wait    = LONG_HOLD;
         end
         rsp_stall <= (rsp_wait > 0);
         if (rsp_valid && rsp_wait > 0) rsp_wait--;
      end
   end

   // Predict on accepted ops, check accepted result words
   always @(posedge clock) begin : watch_channels
      answer_type want;
      req_taken = !reset && req_valid && !req_stall;
      rsp_taken = !reset && rsp_valid && !rsp_stall;
      if (req_taken)
         expected_answers.push_back(apply_frame_op(cfa_pkg::op_type'(req_operation),
                                                   req_frame_number, req_count));
      if (rsp_taken) begin
         if (expected_answers.size() == 0) begin
            $error("unexpected result word: result_frame 0x%05h status %0d",
                   rsp_result_frame, rsp_status);
            fail_count++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_result_frame !== want.result_frame) begin
               $error("result_frame: expected 0x%05h, actual 0x%05h",
                      want.result_frame, rsp_result_frame);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: ends the run when no channel moves for too long
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   task automatic write_csr(cfa_pkg::csr_index_type idx,
                            logic [cfa_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         cfa_pkg::CSR_BASE_FRAME: cfg_base       = data[cfa_pkg::FRAME_W-1:0];
         cfa_pkg::CSR_POOL_SIZE:  cfg_pool       = data[cfa_pkg::POOL_W-1:0];
         cfa_pkg::CSR_MAP_INSIDE: cfg_map_inside = data[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Holds the sender until every queued op has answered
   task automatic drain();
      while (op_queue.size() != 0 || req_valid || expected_answers.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_pool(logic [cfa_pkg::FRAME_W-1:0] base,
                           logic [cfa_pkg::POOL_W-1:0] pool, logic map_in);
      drain();
      write_csr(cfa_pkg::CSR_BASE_FRAME, base);
      write_csr(cfa_pkg::CSR_POOL_SIZE, cfa_pkg::CSR_DATA_W'(pool));
      write_csr(cfa_pkg::CSR_MAP_INSIDE, cfa_pkg::CSR_DATA_W'(map_in));
   endtask

   // Keeps the op queue short so head picks follow the shadow map closely
   task automatic queue_op(cfa_pkg::op_type op, logic [cfa_pkg::FRAME_W-1:0] frame,
                           logic [cfa_pkg::COUNT_W-1:0] count);
      frame_op_type w;
      while (op_queue.size() >= 2) @(posedge clock);
      w.op    = op;
      w.frame = frame;
      w.count = count;
      op_queue.push_back(w);
   endtask

   // Mostly allocate/release traffic on live heads, some reserves, rare clears, noise
   task automatic queue_random_op();
      int unsigned r, q;
      r = $urandom_range(0, 99);
      q = $urandom_range(0, 9);
      if (r < 40) begin
         queue_op(cfa_pkg::OP_ALLOCATE, cfa_pkg::FRAME_W'($urandom), draw_count());
      end else if (r < 70) begin
         queue_op(cfa_pkg::OP_RELEASE,
                  (q < 8) ? pick_head() : (q < 9) ? pool_frame()
                                                  : cfa_pkg::FRAME_W'($urandom),
                  cfa_pkg::COUNT_W'($urandom));
      end else if (r < 85) begin
         queue_op(cfa_pkg::OP_RESERVE,
                  (q < 8) ? pool_frame() : cfa_pkg::FRAME_W'($urandom), draw_count());
      end else if (r < 88) begin
         queue_op(cfa_pkg::OP_CLEAR, cfa_pkg::FRAME_W'($urandom),
                  cfa_pkg::COUNT_W'($urandom));
      end else begin
         queue_op(cfa_pkg::op_type'($urandom_range(0, 3)), cfa_pkg::FRAME_W'($urandom),
                  cfa_pkg::COUNT_W'($urandom));
      end
   endtask

   initial begin : stimulus
      logic [cfa_pkg::FRAME_W-1:0]  base;
      logic [cfa_pkg::POOL_W-1:0]   pool;
      foreach (frame_map[k]) frame_map[k] = cfa_pkg::FS_FREE;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Directed: small pool with the map inside it
      set_pool(20'd16, 11'd64, 1'b1);
      queue_op(cfa_pkg::OP_CLEAR,    20'd0,       11'd0);
      queue_op(cfa_pkg::OP_ALLOCATE, 20'd0,       11'd0);     // zero count
      queue_op(cfa_pkg::OP_RESERVE,  20'd16,      11'd0);     // zero count
      queue_op(cfa_pkg::OP_ALLOCATE, 20'd0,       11'd4);
      queue_op(cfa_pkg::OP_ALLOCATE, 20'd0,       11'd65);    // run longer than the pool
      queue_op(cfa_pkg::OP_ALLOCATE, 20'hFFFFF,   11'd2047);
      queue_op(cfa_pkg::OP_RELEASE,  20'd17,      11'd0);
      queue_op(cfa_pkg::OP_RELEASE,  20'd17,      11'd0);     // no longer a head
      queue_op(cfa_pkg::OP_RELEASE,  20'd15,      11'd0);     // below the pool
      queue_op(cfa_pkg::OP_RELEASE,  20'd80,      11'd0);     // just past the pool
      queue_op(cfa_pkg::OP_RESERVE,  20'd76,      11'd5);     // runs past the end
      queue_op(cfa_pkg::OP_RESERVE,  20'd76,      11'd4);
      queue_op(cfa_pkg::OP_RELEASE,  20'd16,      11'd0);     // map frame
      queue_op(cfa_pkg::OP_RESERVE,  20'd16,      11'd64);    // overwrite whole pool
      queue_op(cfa_pkg::OP_RELEASE,  20'd16,      11'd2047);
      queue_op(cfa_pkg::OP_ALLOCATE, 20'd0,       11'd64);

      // Empty pool
      set_pool(20'd16, 11'd0, 1'b1);
      queue_op(cfa_pkg::OP_ALLOCATE, 20'd0,       11'd1);
      queue_op(cfa_pkg::OP_RELEASE,  20'd16,      11'd0);
      queue_op(cfa_pkg::OP_RESERVE,  20'd16,      11'd1);
      queue_op(cfa_pkg::OP_CLEAR,    20'd0,       11'd0);

      // Oversized pool at the top of the frame space, result wraps
      set_pool(20'hFFFFF, 11'd2047, 1'b0);
      queue_op(cfa_pkg::OP_CLEAR,    20'd0,       11'd0);
      queue_op(cfa_pkg::OP_ALLOCATE, 20'd0,       11'd1024);
      queue_op(cfa_pkg::OP_RELEASE,  20'hFFFFF,   11'd0);
      queue_op(cfa_pkg::OP_ALLOCATE, 20'd0,       11'd1);
      queue_op(cfa_pkg::OP_ALLOCATE, 20'd0,       11'd3);

      // Shrink and regrow the pool; frame 0 lies below the base and stays out of the pool
      set_pool(20'hFFFFF, 11'd1, 1'b0);
      queue_op(cfa_pkg::OP_RELEASE,  20'd0,       11'd0);
      set_pool(20'hFFFFF, 11'd1024, 1'b0);
      queue_op(cfa_pkg::OP_RELEASE,  20'd0,       11'd0);

      // Random phases, a new pool setting each time
      for (int p = 0; p < 15; p++) begin
         case (p % 4)
            0:       base = '0;
            1:       base = 20'hFFFFF - cfa_pkg::FRAME_W'($urandom_range(0, 40));
            2:       base = cfa_pkg::FRAME_W'($urandom);
            default: base = cfa_pkg::FRAME_W'($urandom_range(0, 4095));
         endcase
         case (p)
            3:       pool = 11'd1024;
            6:       pool = 11'd0;
            9:       pool = 11'd2047;
            12:      pool = 11'd1;
            default: pool = cfa_pkg::POOL_W'($urandom_range(8, 96));
         endcase
         set_pool(base, pool, 1'($urandom));
         no_idle = (p % 5 == 2);
         if (p == 1 || p == 10) hold_asked++;
         if (p % 3 == 0)
            queue_op(cfa_pkg::OP_CLEAR, cfa_pkg::FRAME_W'($urandom),
                     cfa_pkg::COUNT_W'($urandom));
         repeat (38) queue_random_op();
      end

      // Wind down: everything answered, then room for a stray word
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (expected_answers.size() != 0) begin
         $error("%0d result words never arrived", expected_answers.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
